// ----- sv/first_fit_interval_allocator_core_macros.svh -----
// ----------------------------------------------------------------------------
// first_fit_interval_allocator_core_macros
// assertion macros for the first-fit interval allocator; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_INTERVAL_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_INTERVAL_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FFIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffia assertion failed");

// next-cycle implication
`define FFIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffia assertion failed");

`else

`define FFIA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FFIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/ffia_pkg.sv -----
// ----------------------------------------------------------------------------
// ffia_pkg
// shared widths, the reset value and state codes of the interval allocator
// ----------------------------------------------------------------------------
package ffia_pkg;

	localparam int TIME_W = 12;
	localparam int IDX_W  = 5;
	localparam int USED_W = 6;

	localparam logic [TIME_W-1:0] LATEST_RESET = 12'd2359;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

// ----- sv/ffia_ram.sv -----
// ----------------------------------------------------------------------------
// ffia_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ffia_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/first_fit_interval_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_interval_allocator_core
// places intervals on the lowest free platform, busy-until times kept in ram
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | start_case, arrive_time, depart_time
//  out     | output    | out_valid/out_ready| platform_index, platforms_used,
//          |           |                    | invalid_time, no_room
//  cfg     | input     | cfg_we             | cfg_wdata (latest_time)
//
// an item that lands on platform j scans platforms 0 to j; when a new platform
// opens or the store is full, every open platform is scanned; an invalid time
// or an empty case skips the scan. one ram read per cycle sets the scan length.
// reset clears control state only; the busy-until ram needs no clearing pass.
// a waiting result is held in the output register while the next item enters.
`include "first_fit_interval_allocator_core_macros.svh"

module first_fit_interval_allocator_core #(
	parameter int MAX_PLATFORMS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ffia_pkg::TIME_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         start_case,
	input  logic [ffia_pkg::TIME_W-1:0]  arrive_time,
	input  logic [ffia_pkg::TIME_W-1:0]  depart_time,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ffia_pkg::IDX_W-1:0]   platform_index,
	output logic [ffia_pkg::USED_W-1:0]  platforms_used,
	output logic                         invalid_time,
	output logic                         no_room
);

	import ffia_pkg::*;

	localparam int CW = $clog2(MAX_PLATFORMS + 1);
	localparam int IW = MAX_PLATFORMS > 1 ? $clog2(MAX_PLATFORMS) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PLATFORMS);

	state_t              state_q;
	logic [TIME_W-1:0]   latest_q;
	logic [TIME_W-1:0]   arr_q;
	logic [TIME_W-1:0]   dep_q;
	logic                bad_q;
	logic                found_q;
	logic [IW-1:0]       slot_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       idx_q;
	logic                rd_vld_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [USED_W-1:0]   out_used_q;
	logic                out_bad_q;
	logic                out_full_q;

	logic                in_fire;
	logic                in_bad;
	logic [CW-1:0]       cnt_start;
	logic                issue;
	logic                hit;
	logic                last;
	logic                out_free;
	logic                finish;
	logic                can_open;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [TIME_W-1:0]   ram_rdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign in_bad    = (arrive_time > latest_q) || (depart_time > latest_q);
	assign cnt_start = start_case ? '0 : cnt_q;

	assign issue = (state_q == ST_SCAN) && (idx_q < cnt_q);
	assign hit   = rd_vld_s1 && (arr_q > ram_rdata);
	assign last  = rd_vld_s1 && ((CW'(rd_idx_s1) + CW'(1)) == cnt_q);

	assign out_free  = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_DONE) && out_free;
	assign can_open  = cnt_q < MAX_CNT;
	assign ram_we    = finish && !bad_q && (found_q || can_open);
	assign ram_waddr = found_q ? slot_q : cnt_q[IW-1:0];

	ffia_ram #(
		.WIDTH (TIME_W),
		.DEPTH (MAX_PLATFORMS)
	) u_busy_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (dep_q),
		.re    (issue),
		.raddr (idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q <= LATEST_RESET;
		end else if (cfg_we) begin
			latest_q <= cfg_wdata;
		end
	end

	// control path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			bad_q     <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						bad_q     <= in_bad;
						found_q   <= 1'b0;
						idx_q     <= '0;
						rd_vld_s1 <= 1'b0;
						if (!in_bad) begin
							cnt_q <= cnt_start;
						end
						// nothing to scan when the time is bad or no platform is open
						if (in_bad || cnt_start == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit || last) begin
						found_q   <= hit;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_DONE;
					end else begin
						rd_vld_s1 <= issue;
						if (issue) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (!bad_q && !found_q && can_open) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			arr_q <= arrive_time;
			dep_q <= depart_time;
		end
		if (issue) begin
			rd_idx_s1 <= idx_q[IW-1:0];
		end
		if (hit) begin
			slot_q <= rd_idx_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_bad_q  <= bad_q;
			out_full_q <= !bad_q && !found_q && !can_open;
			if (bad_q || (!found_q && !can_open)) begin
				out_idx_q  <= '0;
				out_used_q <= USED_W'(cnt_q);
			end else if (found_q) begin
				out_idx_q  <= IDX_W'(slot_q);
				out_used_q <= USED_W'(cnt_q);
			end else begin
				out_idx_q  <= IDX_W'(cnt_q);
				out_used_q <= USED_W'(cnt_q + CW'(1));
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign platform_index = out_idx_q;
	assign platforms_used = out_used_q;
	assign invalid_time   = out_bad_q;
	assign no_room        = out_full_q;

	`FFIA_ASSERT_IMP(a_we_only_done, clk, arst_n, ram_we, state_q == ST_DONE)
	`FFIA_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= MAX_CNT)
	`FFIA_ASSERT_IMP(a_rd_in_scan, clk, arst_n, rd_vld_s1, state_q == ST_SCAN)
	`FFIA_ASSERT_IMP(a_flags_excl, clk, arst_n, out_valid_q && out_bad_q, !out_full_q)
	`FFIA_ASSERT_NEXT(a_result_after_done, clk, arst_n, finish, out_valid_q)

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// first-fit platform allocator: intervals are placed by a local model of the
// busy-until store and every result is compared field by field, under random
// sender gaps, receiver stalls and a long output hold-off
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffia_pkg::*;

	localparam int NUM_PLATS   = 32;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 50;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [USED_W-1:0] used;
		logic              bad;
		logic              full;
	} placement_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [TIME_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic              start_case;
	logic [TIME_W-1:0] arrive_time;
	logic [TIME_W-1:0] depart_time;
	logic              out_valid;
	logic              out_ready;
	logic [IDX_W-1:0]  platform_index;
	logic [USED_W-1:0] platforms_used;
	logic              invalid_time;
	logic              no_room;

	// allocator model state
	logic [TIME_W-1:0] plat_free_after [NUM_PLATS];
	int                open_plats;
	logic [TIME_W-1:0] time_limit;

	placement_t expected_placements [$];
	int         mismatches;
	int         cycle_count;
	bit         idle_on;
	bit         hold_req;
	int         send_idle_pct;
	int         recv_idle_pct;

	first_fit_interval_allocator_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.start_case     (start_case),
		.arrive_time    (arrive_time),
		.depart_time    (depart_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.platform_index (platform_index),
		.platforms_used (platforms_used),
		.invalid_time   (invalid_time),
		.no_room        (no_room)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic placement_t place_interval(input logic fresh,
			input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] dep);
		placement_t r;
		bit hit;
		r = '0;
		hit = 1'b0;
		if (arr > time_limit || dep > time_limit) begin
			r.bad = 1'b1;
		end else begin
			if (fresh)
				open_plats = 0;
			// lowest platform that frees strictly before the arrival wins
			for (int k = 0; k < open_plats; k++) begin
				if (!hit && arr > plat_free_after[k]) begin
					hit = 1'b1;
					r.idx = IDX_W'(k);
				end
			end
			if (hit) begin
				plat_free_after[r.idx] = dep;
			end else if (open_plats < NUM_PLATS) begin
				r.idx = IDX_W'(open_plats);
				plat_free_after[open_plats] = dep;
				open_plats++;
			end else begin
				r.full = 1'b1;
			end
		end
		r.used = USED_W'(open_plats);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_check
		placement_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_placements.size() == 0) begin
				report_mismatch("result with nothing pending", platform_index, 0);
			end else begin
				want = expected_placements.pop_front();
				if (platform_index !== want.idx)
					report_mismatch("platform_index", platform_index, want.idx);
				if (platforms_used !== want.used)
					report_mismatch("platforms_used", platforms_used, want.used);
				if (invalid_time !== want.bad)
					report_mismatch("invalid_time", invalid_time, want.bad);
				if (no_room !== want.full)
					report_mismatch("no_room", no_room, want.full);
			end
		end
	end

	// receiver: random stall bursts, or one long hold when asked
	initial begin : receiver
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_ready = 1'b1;
			end else if (idle_on && $urandom_range(0, 99) < recv_idle_pct) begin
				out_ready = 1'b0;
				gap = $urandom_range(1, 14);
				repeat (gap) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_interval(input logic fresh, input logic [TIME_W-1:0] arr,
			input logic [TIME_W-1:0] dep);
		int gap;
		if (idle_on && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(negedge clk);
		end
		in_valid    = 1'b1;
		start_case  = fresh;
		arrive_time = arr;
		depart_time = dep;
		do
			@(posedge clk);
		while (!in_ready);
		expected_placements.push_back(place_interval(fresh, arr, dep));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (expected_placements.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_latest(input logic [TIME_W-1:0] v);
		drain();
		repeat (SETTLE) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we     = 1'b0;
		time_limit = v;
	endtask

	// cases of intervals with rising arrivals, mixed with raw noise items;
	// only intervals within the time limit count toward n_valid
	task automatic run_cases(input int n_valid, input int noise_pct);
		int done, len, lim, t, a, d, step;
		logic fresh;
		done = 0;
		while (done < n_valid) begin
			lim  = time_limit;
			len  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 20);
			step = ($urandom_range(0, 3) == 0) ? 2 : lim / 16 + 1;
			t    = $urandom_range(0, lim / 2);
			for (int k = 0; k < len && done < n_valid; k++) begin
				if ($urandom_range(0, 99) < noise_pct) begin
					a     = $urandom_range(0, 4095);
					d     = $urandom_range(0, 4095);
					fresh = 1'($urandom_range(0, 1));
				end else begin
					t = t + $urandom_range(0, step);
					if (t > lim)
						t = lim;
					a = t;
					d = a + $urandom_range(0, lim / 4 + 1);
					if (d > lim)
						d = lim;
					// departure at or before arrival
					if ($urandom_range(0, 19) == 0)
						d = $urandom_range(0, a);
					fresh = (k == 0);
				end
				send_interval(fresh, a[TIME_W-1:0], d[TIME_W-1:0]);
				if (a <= lim && d <= lim)
					done++;
			end
		end
	endtask

	task automatic test_directed_edges();
		send_interval(1'b0, 12'd100, 12'd200);   // no case opened yet
		send_interval(1'b1, 12'd0, 12'd0);
		send_interval(1'b0, 12'd0, 12'd2359);    // equal to busy-until, not free
		send_interval(1'b0, 12'd1, 12'd5);
		send_interval(1'b0, 12'd5, 12'd3);       // departs before it arrives
		send_interval(1'b0, 12'd6, 12'd0);
		send_interval(1'b0, 12'd2360, 12'd10);
		send_interval(1'b0, 12'd10, 12'd2360);
		send_interval(1'b1, 12'd4095, 12'd4095); // ignored, case survives
		send_interval(1'b0, 12'd4, 12'd4);
		send_interval(1'b1, 12'd2359, 12'd2359);
		send_interval(1'b0, 12'd2359, 12'd0);
		send_interval(1'b1, 12'd0, 12'd4095);
		send_interval(1'b0, 12'd2359, 12'd2359);
		send_interval(1'b0, 12'd1, 12'd1);
		send_interval(1'b0, 12'd2, 12'd1234);
		send_interval(1'b1, 12'd2048, 12'd1024);
		send_interval(1'b0, 12'd2049, 12'd2359);
	endtask

	// every platform held to the limit, then a few that find no room
	task automatic test_store_full();
		for (int k = 0; k < NUM_PLATS + 3; k++)
			send_interval(k == 0, 12'($urandom_range(0, time_limit)), time_limit);
		send_interval(1'b0, time_limit, 12'd0);
		send_interval(1'b1, 12'd0, 12'd0);
	endtask

	task automatic test_random_cases();
		send_idle_pct = 25;
		recv_idle_pct = 20;
		run_cases(100, 8);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_cases(40, 8);
		send_idle_pct = 10;
		recv_idle_pct = 40;
		run_cases(60, 8);
	endtask

	task automatic test_latest_sweep();
		send_idle_pct = 20;
		recv_idle_pct = 20;
		set_latest(12'd4095);
		run_cases(150, 30);
		test_store_full();
		set_latest(12'd0);
		run_cases(30, 20);
		set_latest(12'($urandom_range(1, 300)));
		run_cases(80, 15);
		set_latest(12'($urandom_range(301, 4094)));
		run_cases(60, 15);
	endtask

	task automatic test_output_hold();
		set_latest(12'd2359);
		hold_req = 1'b1;
		run_cases(60, 5);
	endtask

	task automatic test_streaming_tail();
		drain();
		idle_on = 1'b0;
		run_cases(100, 5);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		start_case    = 1'b0;
		arrive_time   = '0;
		depart_time   = '0;
		mismatches    = 0;
		cycle_count   = 0;
		idle_on       = 1'b1;
		hold_req      = 1'b0;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		open_plats    = 0;
		time_limit    = LATEST_RESET;
		for (int k = 0; k < NUM_PLATS; k++)
			plat_free_after[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_store_full();
		test_random_cases();
		test_latest_sweep();
		test_output_hold();
		test_streaming_tail();

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ffia_pkg.sv
sv/ffia_ram.sv
sv/first_fit_interval_allocator_core.sv
tb/testbench.sv
